>>> hdl/rlp_pkg.sv
// ----------------------------------------------------------------------------
// rlp_pkg: shared types and constants of the radix literal parser
// Beat payloads, parse phases, radix and error codes, ASCII constants and
// the digit decoder.
// ----------------------------------------------------------------------------
package rlp_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         error_code;
        logic [1:0]         radix_used;
    } result_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_HEX_BEGIN,
        PH_HEX_BODY,
        PH_OCT_BODY,
        PH_FREE_BODY
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_OCT = 2'd0,
        RADIX_DEC = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_EMPTY   = 2'd1,
        ERR_INVALID = 2'd2,
        ERR_RANGE   = 2'd3
    } err_t;

    localparam int NUM_RADIX = 3;

    localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
    localparam logic [7:0] CH_X_LOWER = 8'h78;  // 'x'
    localparam logic [7:0] CH_X_UPPER = 8'h58;  // 'X'
    localparam logic [7:0] CH_H       = 8'h48;  // 'H'
    localparam logic [7:0] CH_B       = 8'h42;  // 'B'
    localparam logic [7:0] CH_PLUS    = 8'h2b;  // '+'
    localparam logic [7:0] CH_MINUS   = 8'h2d;  // '-'
    localparam logic [7:0] CH_A_LOWER = 8'h61;  // 'a'
    localparam logic [7:0] CH_F_LOWER = 8'h66;  // 'f'
    localparam logic [7:0] CH_A_UPPER = 8'h41;  // 'A'
    localparam logic [7:0] CH_F_UPPER = 8'h46;  // 'F'

    // Value 16 marks a character that is no hex digit.
    localparam logic [4:0] DIGIT_NONE = 5'd16;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
                d = 5'(c - CH_ZERO);
            else if (c >= CH_A_LOWER && c <= CH_F_LOWER)
                d = 5'(c - CH_A_LOWER) + 5'd10;
            else if (c >= CH_A_UPPER && c <= CH_F_UPPER)
                d = 5'(c - CH_A_UPPER) + 5'd10;
            else
                d = DIGIT_NONE;
            return d;
        end
    endfunction

    function automatic logic [4:0] base_of(input radix_t r);
        logic [4:0] b;
        begin
            case (r)
                RADIX_OCT: b = 5'd8;
                RADIX_HEX: b = 5'd16;
                default:   b = 5'd10;
            endcase
            return b;
        end
    endfunction

endpackage

>>> hdl/radix_literal_parser.sv
// ----------------------------------------------------------------------------
// radix_literal_parser: integer literal parser, one character per beat
// A last character passes the input register, then its result the result
// register. Throughput: one character per cycle; a final one waits while
// the result register is full and not draining. Per character, one pass of
// decode, three accumulator lanes and a sign fix lies between two registers.
// Reset: async active-low; clears the parse state, input and result valids.
// ----------------------------------------------------------------------------
module radix_literal_parser #(
    parameter int VALUE_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  rlp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output rlp_pkg::result_t result
);
    import rlp_pkg::*;

    // Input register: one character beat waiting for the parse stage.
    item_t  item_reg;
    logic   item_valid_reg;

    // Parse state, cleared after every result.
    phase_t                phase_reg, phase_next;
    logic                  neg_reg;
    logic [1:0]            dcount_reg;
    logic [VALUE_BITS-1:0] acc_reg [NUM_RADIX];
    logic [NUM_RADIX-1:0]  ovf_reg;
    logic [NUM_RADIX-1:0]  inv_reg;

    // Result register.
    result_t result_reg, result_next;
    logic    result_valid_reg;

    // Decode of the current character.
    logic [7:0]           c;
    logic                 last;
    logic                 take;       // character enters the digit part
    logic                 begin_dp;   // first character of the digit part
    logic [NUM_RADIX-1:0] mask;
    logic                 fin;
    radix_t               fin_radix;
    logic                 lone_zero;

    logic                  sign_take;
    logic                  digit_take;
    logic [4:0]            digit;
    logic                  neg_upd;
    logic [1:0]            dcount_upd;
    logic [VALUE_BITS-1:0] acc_upd [NUM_RADIX];
    logic [NUM_RADIX-1:0]  ovf_upd;
    logic [NUM_RADIX-1:0]  inv_upd;

    logic                  advance;

    assign c    = item_reg.char_code;
    assign last = item_reg.last_char;

    // ------------------------------------------------------------------
    // Next phase and digit-part control. The radix is chosen either by a
    // leading prefix or, in the free body, by the last character.
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        take       = 1'b0;
        begin_dp   = 1'b0;
        mask       = '0;
        fin        = 1'b0;
        fin_radix  = RADIX_DEC;
        lone_zero  = 1'b0;
        case (phase_reg)
            PH_ZERO:
            begin
                if (c == CH_X_LOWER || c == CH_X_UPPER)
                begin
                    phase_next = PH_HEX_BEGIN;
                    fin        = last;
                    fin_radix  = RADIX_HEX;
                end
                else
                begin
                    // a leading zero not followed by x: octal
                    phase_next = PH_OCT_BODY;
                    take       = 1'b1;
                    begin_dp   = 1'b1;
                    mask[RADIX_OCT] = 1'b1;
                    fin        = last;
                    fin_radix  = RADIX_OCT;
                end
            end
            PH_HEX_BEGIN, PH_HEX_BODY:
            begin
                phase_next = PH_HEX_BODY;
                take       = 1'b1;
                begin_dp   = (phase_reg == PH_HEX_BEGIN);
                mask[RADIX_HEX] = 1'b1;
                fin        = last;
                fin_radix  = RADIX_HEX;
            end
            PH_OCT_BODY:
            begin
                take       = 1'b1;
                mask[RADIX_OCT] = 1'b1;
                fin        = last;
                fin_radix  = RADIX_OCT;
            end
            PH_FREE_BODY:
            begin
                fin = last;
                if (last && c == CH_H)
                    fin_radix = RADIX_HEX;
                else if (last && c == CH_B)
                    fin_radix = RADIX_OCT;
                else
                begin
                    take = 1'b1;
                    mask = '1;
                end
            end
            default:
            begin
                // start of a literal; state is already clear here
                if (c == CH_ZERO)
                begin
                    if (last)
                    begin
                        lone_zero = 1'b1;
                        fin       = 1'b1;
                        fin_radix = RADIX_OCT;
                    end
                    else
                        phase_next = PH_ZERO;
                end
                else
                begin
                    phase_next = PH_FREE_BODY;
                    fin        = last;
                    if (last && c == CH_H)
                        fin_radix = RADIX_HEX;
                    else if (last && c == CH_B)
                        fin_radix = RADIX_OCT;
                    else
                    begin
                        take     = 1'b1;
                        begin_dp = 1'b1;
                        mask     = '1;
                    end
                end
            end
        endcase
    end

    // A sign is only taken at the very start of the digit part.
    assign sign_take  = take && begin_dp && (c == CH_PLUS || c == CH_MINUS);
    assign digit_take = take && !sign_take;
    assign digit      = digit_of(c);
    assign neg_upd    = sign_take ? (c == CH_MINUS) : neg_reg;

    always_comb
    begin
        if (lone_zero)
            dcount_upd = 2'd1;
        else if (digit_take && dcount_reg != 2'd2)
            dcount_upd = dcount_reg + 2'd1;
        else
            dcount_upd = dcount_reg;
    end

    // Octal, decimal and hex lanes run side by side.
    for (genvar i = 0; i < NUM_RADIX; i++)
    begin : g_lane
        rlp_lane #(
            .VALUE_BITS (VALUE_BITS),
            .LANE       (radix_t'(i))
        ) u_lane (
            .en      (digit_take && mask[i]),
            .digit   (digit),
            .acc     (acc_reg[i]),
            .ovf     (ovf_reg[i]),
            .inv     (inv_reg[i]),
            .acc_upd (acc_upd[i]),
            .ovf_upd (ovf_upd[i]),
            .inv_upd (inv_upd[i])
        );
    end

    // ------------------------------------------------------------------
    // Result of a finishing character. Invalid beats empty, empty beats
    // out of range. The magnitude never passes 2^(VALUE_BITS-1), so a
    // positive value is out of range exactly when its top bit is set.
    // ------------------------------------------------------------------
    logic [VALUE_BITS-1:0]        mag;
    logic signed [VALUE_BITS-1:0] signed_val;

    assign mag        = acc_upd[fin_radix];
    assign signed_val = neg_upd ? -mag : mag;

    always_comb
    begin
        result_next            = '0;
        result_next.radix_used = fin_radix;
        if (inv_upd[fin_radix])
            result_next.error_code = ERR_INVALID;
        else if (dcount_upd == 2'd0)
            result_next.error_code = ERR_EMPTY;
        else if (ovf_upd[fin_radix] || (!neg_upd && mag[VALUE_BITS-1]))
            result_next.error_code = ERR_RANGE;
        else
        begin
            result_next.error_code = ERR_OK;
            result_next.value      = 32'(signed_val);
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A non-final character never waits on the result side; a
    // final one advances when the result register is free or draining.
    // ------------------------------------------------------------------
    assign advance    = item_valid_reg && (!fin || !result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item_ready)
            item_valid_reg <= item_valid;
    end

    // payload holds while the beat waits
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            neg_reg    <= 1'b0;
            dcount_reg <= 2'd0;
            ovf_reg    <= '0;
            inv_reg    <= '0;
            for (int i = 0; i < NUM_RADIX; i++)
                acc_reg[i] <= '0;
        end
        else if (advance)
        begin
            if (fin)
            begin
                // drop all parse state for the next literal
                phase_reg  <= PH_START;
                neg_reg    <= 1'b0;
                dcount_reg <= 2'd0;
                ovf_reg    <= '0;
                inv_reg    <= '0;
                for (int i = 0; i < NUM_RADIX; i++)
                    acc_reg[i] <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                neg_reg    <= neg_upd;
                dcount_reg <= dcount_upd;
                ovf_reg    <= ovf_upd;
                inv_reg    <= inv_upd;
                for (int i = 0; i < NUM_RADIX; i++)
                    acc_reg[i] <= acc_upd[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance && fin)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && fin)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    localparam logic [VALUE_BITS-1:0] MAG_LIMIT = VALUE_BITS'(1) << (VALUE_BITS - 1);

    a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.error_code != ERR_OK |-> result.value == 0)
        else $error("error result carries a nonzero value");

    a_clear_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        advance && fin |=> phase_reg == PH_START && dcount_reg == 2'd0 && !neg_reg)
        else $error("parse state not cleared after a result");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg[RADIX_OCT] <= MAG_LIMIT && acc_reg[RADIX_DEC] <= MAG_LIMIT
        && acc_reg[RADIX_HEX] <= MAG_LIMIT)
        else $error("accumulator above range limit");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("stalled character beat lost");

endmodule

>>> hdl/rlp_lane.sv
// ----------------------------------------------------------------------------
// rlp_lane: one radix accumulator lane
// Folds one digit into a magnitude, flagging a non-digit or a magnitude
// that passes the signed range limit.
// ----------------------------------------------------------------------------
module rlp_lane #(
    parameter int              VALUE_BITS = 32,
    parameter rlp_pkg::radix_t LANE       = rlp_pkg::RADIX_DEC
) (
    input  logic                  en,
    input  logic [4:0]            digit,
    input  logic [VALUE_BITS-1:0] acc,
    input  logic                  ovf,
    input  logic                  inv,
    output logic [VALUE_BITS-1:0] acc_upd,
    output logic                  ovf_upd,
    output logic                  inv_upd
);
    import rlp_pkg::*;

    localparam int WIDE_W = VALUE_BITS + 5;
    localparam logic [WIDE_W-1:0] LIMIT = WIDE_W'(1) << (VALUE_BITS - 1);
    localparam logic [4:0] BASE = base_of(LANE);

    logic [WIDE_W-1:0] acc_wide;
    logic [WIDE_W-1:0] scaled;
    logic [WIDE_W-1:0] prod;

    assign acc_wide = WIDE_W'(acc);

    always_comb
    begin
        case (LANE)
            RADIX_OCT: scaled = acc_wide << 3;
            RADIX_HEX: scaled = acc_wide << 4;
            default:   scaled = (acc_wide << 3) + (acc_wide << 1);
        endcase
    end

    assign prod = scaled + WIDE_W'(digit);

    always_comb
    begin
        acc_upd = acc;
        ovf_upd = ovf;
        inv_upd = inv;
        if (en)
        begin
            if (digit >= BASE)
                inv_upd = 1'b1;
            else if (!ovf)
            begin
                // hold the magnitude once it passes the limit
                if (prod > LIMIT)
                    ovf_upd = 1'b1;
                else
                    acc_upd = prod[VALUE_BITS-1:0];
            end
        end
    end

endmodule
